>>> hdl/lpfd_pkg.sv
// Package for the length-prefixed frame deframer.
// Holds the register indexes, the parse states, the result codes and the shared structs.
// No dependencies.
`default_nettype none

package lpfd_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEADER      = 3'd0,
    REG_ASK_TYPE    = 3'd1,
    REG_REPLY_TYPE  = 3'd2,
    REG_VERSION     = 3'd3,
    REG_KEY_VERSION = 3'd4,
    REG_END         = 3'd5,
    REG_LEN_LIMIT   = 3'd6,
    REG_CHECK_EN    = 3'd7
  } lpfd_reg_t;

  localparam logic [7:0]  RST_HEADER      = 8'hAA;
  localparam logic [7:0]  RST_ASK_TYPE    = 8'h01;
  localparam logic [7:0]  RST_REPLY_TYPE  = 8'h02;
  localparam logic [7:0]  RST_VERSION     = 8'h10;
  localparam logic [7:0]  RST_KEY_VERSION = 8'h10;
  localparam logic [7:0]  RST_END         = 8'h55;
  localparam logic [15:0] RST_LEN_LIMIT   = 16'd512;
  localparam logic        RST_CHECK_EN    = 1'b1;

  typedef enum logic [1:0] {
    RK_PAYLOAD = 2'd0,
    RK_DONE    = 2'd1,
    RK_DROP    = 2'd2
  } lpfd_rkind_t;

  typedef enum logic [14:0] {
    ST_HUNT    = 15'h0001,
    ST_TYPE    = 15'h0002,
    ST_VERSION = 15'h0004,
    ST_MKIND   = 15'h0008,
    ST_MNUM0   = 15'h0010,
    ST_MNUM1   = 15'h0020,
    ST_MNUM2   = 15'h0040,
    ST_MNUM3   = 15'h0080,
    ST_KEYVER  = 15'h0100,
    ST_CMD     = 15'h0200,
    ST_LEN_LO  = 15'h0400,
    ST_LEN_HI  = 15'h0800,
    ST_PAYLOAD = 15'h1000,
    ST_CHECK   = 15'h2000,
    ST_END     = 15'h4000
  } lpfd_step_t;

  typedef struct packed {
    logic [7:0]  header_value;
    logic [7:0]  ask_type_value;
    logic [7:0]  reply_type_value;
    logic [7:0]  version_value;
    logic [7:0]  key_version_value;
    logic [7:0]  end_value;
    logic [15:0] length_limit;
    logic        check_enable;
  } lpfd_cfg_t;

  typedef struct packed {
    lpfd_rkind_t result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        is_reply;
    logic [7:0]  machine_kind;
    logic [31:0] machine_number;
    logic [7:0]  command_code;
    logic [15:0] payload_length;
  } lpfd_result_t;

endpackage

`default_nettype wire

>>> hdl/lpfd_if.sv
// Channel interfaces for the length-prefixed frame deframer.
// Input byte channel and result channel, valid/ready handshake.
// Depends on nothing.
`default_nettype none

interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

interface lpfd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic        is_reply;
  logic [7:0]  machine_kind;
  logic [31:0] machine_number;
  logic [7:0]  command_code;
  logic [15:0] payload_length;

  modport source (
    output valid, output result_kind, output payload_byte, output payload_index,
    output is_reply, output machine_kind, output machine_number, output command_code,
    output payload_length, input ready
  );
  modport sink (
    input valid, input result_kind, input payload_byte, input payload_index,
    input is_reply, input machine_kind, input machine_number, input command_code,
    input payload_length, output ready
  );
endinterface

`default_nettype wire

>>> hdl/lpfd_cfg_regs.sv
// Configuration register file of the deframer.
// Plain write port, one register per index; depends on lpfd_pkg.
`default_nettype none

module lpfd_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpfd_pkg::CFG_DATA_W-1:0] cfg_data,
  output lpfd_pkg::lpfd_cfg_t                 cfg
);
  import lpfd_pkg::*;

  lpfd_cfg_t cfg_r;
  lpfd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (lpfd_reg_t'(cfg_index))
        REG_HEADER:      cfg_nxt.header_value      = cfg_data[7:0];
        REG_ASK_TYPE:    cfg_nxt.ask_type_value    = cfg_data[7:0];
        REG_REPLY_TYPE:  cfg_nxt.reply_type_value  = cfg_data[7:0];
        REG_VERSION:     cfg_nxt.version_value     = cfg_data[7:0];
        REG_KEY_VERSION: cfg_nxt.key_version_value = cfg_data[7:0];
        REG_END:         cfg_nxt.end_value         = cfg_data[7:0];
        REG_LEN_LIMIT:   cfg_nxt.length_limit      = cfg_data[15:0];
        REG_CHECK_EN:    cfg_nxt.check_enable      = cfg_data[0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_value      <= RST_HEADER;
      cfg_r.ask_type_value    <= RST_ASK_TYPE;
      cfg_r.reply_type_value  <= RST_REPLY_TYPE;
      cfg_r.version_value     <= RST_VERSION;
      cfg_r.key_version_value <= RST_KEY_VERSION;
      cfg_r.end_value         <= RST_END;
      cfg_r.length_limit      <= RST_LEN_LIMIT;
      cfg_r.check_enable      <= RST_CHECK_EN;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

>>> hdl/lpfd_parse.sv
// Frame parse engine: one byte or release per cycle while acc is high, one optional result.
// Keeps the parse state, running XOR, counters and header fields; depends on lpfd_pkg.
`default_nettype none

module lpfd_parse (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         acc,
  input  wire logic         kind,
  input  wire logic [7:0]   rx_byte,
  input  wire lpfd_pkg::lpfd_cfg_t cfg,
  output logic              res_valid,
  output lpfd_pkg::lpfd_result_t res
);
  import lpfd_pkg::*;

  lpfd_step_t  step_r, step_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] flen_r, flen_nxt;
  logic        held_r, held_nxt;
  logic        reply_r, reply_nxt;
  logic [7:0]  mkind_r, mkind_nxt;
  logic [31:0] mnum_r, mnum_nxt;
  logic [7:0]  cmd_r, cmd_nxt;

  lpfd_rkind_t rkind;
  logic [7:0]  rbyte;
  logic [15:0] ridx;
  logic [15:0] len_full;

  always_comb begin
    step_nxt  = step_r;
    xor_nxt   = xor_r;
    count_nxt = count_r;
    flen_nxt  = flen_r;
    held_nxt  = held_r;
    reply_nxt = reply_r;
    mkind_nxt = mkind_r;
    mnum_nxt  = mnum_r;
    cmd_nxt   = cmd_r;
    res_valid = 1'b0;
    rkind     = RK_PAYLOAD;
    rbyte     = 8'd0;
    ridx      = 16'd0;
    len_full  = {rx_byte, flen_r[7:0]};

    if (acc) begin
      if (kind) begin
        held_nxt = 1'b0;
      end else begin
        case (step_r)
          ST_HUNT: begin
            if (rx_byte == cfg.header_value && !held_r) begin
              xor_nxt   = 8'd0;
              count_nxt = 16'd0;
              flen_nxt  = 16'd0;
              reply_nxt = 1'b0;
              mkind_nxt = 8'd0;
              mnum_nxt  = 32'd0;
              cmd_nxt   = 8'd0;
              step_nxt  = ST_TYPE;
            end
          end
          ST_TYPE: begin
            if (rx_byte == cfg.ask_type_value) begin
              reply_nxt = 1'b0;
              step_nxt  = ST_VERSION;
            end else if (rx_byte == cfg.reply_type_value) begin
              reply_nxt = 1'b1;
              step_nxt  = ST_VERSION;
            end else begin
              step_nxt  = ST_HUNT;
              res_valid = 1'b1;
              rkind     = RK_DROP;
            end
          end
          ST_VERSION: begin
            if (rx_byte != cfg.version_value) begin
              step_nxt  = ST_HUNT;
              res_valid = 1'b1;
              rkind     = RK_DROP;
            end else begin
              xor_nxt  = rx_byte;
              step_nxt = ST_MKIND;
            end
          end
          ST_MKIND: begin
            mkind_nxt = rx_byte;
            xor_nxt   = xor_r ^ rx_byte;
            step_nxt  = ST_MNUM0;
          end
          ST_MNUM0: begin
            mnum_nxt = {24'd0, rx_byte};
            xor_nxt  = xor_r ^ rx_byte;
            step_nxt = ST_MNUM1;
          end
          ST_MNUM1: begin
            mnum_nxt = mnum_r | {16'd0, rx_byte, 8'd0};
            xor_nxt  = xor_r ^ rx_byte;
            step_nxt = ST_MNUM2;
          end
          ST_MNUM2: begin
            mnum_nxt = mnum_r | {8'd0, rx_byte, 16'd0};
            xor_nxt  = xor_r ^ rx_byte;
            step_nxt = ST_MNUM3;
          end
          ST_MNUM3: begin
            mnum_nxt = mnum_r | {rx_byte, 24'd0};
            xor_nxt  = xor_r ^ rx_byte;
            step_nxt = ST_KEYVER;
          end
          ST_KEYVER: begin
            if (rx_byte != cfg.key_version_value) begin
              step_nxt  = ST_HUNT;
              res_valid = 1'b1;
              rkind     = RK_DROP;
            end else begin
              xor_nxt  = xor_r ^ rx_byte;
              step_nxt = ST_CMD;
            end
          end
          ST_CMD: begin
            cmd_nxt  = rx_byte;
            xor_nxt  = xor_r ^ rx_byte;
            step_nxt = ST_LEN_LO;
          end
          ST_LEN_LO: begin
            flen_nxt = {8'd0, rx_byte};
            xor_nxt  = xor_r ^ rx_byte;
            step_nxt = ST_LEN_HI;
          end
          ST_LEN_HI: begin
            flen_nxt = len_full;
            xor_nxt  = xor_r ^ rx_byte;
            if (len_full == 16'd0) begin
              step_nxt = ST_CHECK;
            end else if (len_full >= cfg.length_limit) begin
              step_nxt  = ST_HUNT;
              res_valid = 1'b1;
              rkind     = RK_DROP;
            end else begin
              step_nxt = ST_PAYLOAD;
            end
          end
          ST_PAYLOAD: begin
            count_nxt = count_r + 16'd1;
            xor_nxt   = xor_r ^ rx_byte;
            if (count_nxt >= flen_r) begin
              step_nxt = ST_CHECK;
            end
            res_valid = 1'b1;
            rkind     = RK_PAYLOAD;
            rbyte     = rx_byte;
            ridx      = count_r;
          end
          ST_CHECK: begin
            if (cfg.check_enable && xor_r != rx_byte) begin
              step_nxt  = ST_HUNT;
              res_valid = 1'b1;
              rkind     = RK_DROP;
            end else begin
              step_nxt = ST_END;
            end
          end
          ST_END: begin
            step_nxt  = ST_HUNT;
            res_valid = 1'b1;
            if (rx_byte != cfg.end_value) begin
              rkind = RK_DROP;
            end else begin
              held_nxt = 1'b1;
              rkind    = RK_DONE;
            end
          end
          default: begin
            step_nxt  = ST_HUNT;
            xor_nxt   = 8'd0;
            count_nxt = 16'd0;
          end
        endcase
      end
    end
  end

  always_comb begin
    res.result_kind    = rkind;
    res.payload_byte   = rbyte;
    res.payload_index  = ridx;
    res.is_reply       = reply_nxt;
    res.machine_kind   = mkind_nxt;
    res.machine_number = mnum_nxt;
    res.command_code   = cmd_nxt;
    res.payload_length = flen_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= ST_HUNT;
      xor_r   <= 8'd0;
      count_r <= 16'd0;
      flen_r  <= 16'd0;
      held_r  <= 1'b0;
      reply_r <= 1'b0;
      mkind_r <= 8'd0;
      mnum_r  <= 32'd0;
      cmd_r   <= 8'd0;
    end else begin
      step_r  <= step_nxt;
      xor_r   <= xor_nxt;
      count_r <= count_nxt;
      flen_r  <= flen_nxt;
      held_r  <= held_nxt;
      reply_r <= reply_nxt;
      mkind_r <= mkind_nxt;
      mnum_r  <= mnum_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_res_needs_acc: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> acc && !kind)
    else $error("result without an accepted byte");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.result_kind == RK_DONE) |=> held_r && step_r == ST_HUNT)
    else $error("completed packet did not set the held flag");

  a_payload_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == ST_PAYLOAD) |-> count_r < flen_r)
    else $error("payload count ran past the frame length");
`endif

endmodule

`default_nettype wire

>>> hdl/lpfd_out_buf.sv
// Two-entry result buffer between the parse engine and the result channel.
// Lets a new byte be taken while a finished result waits; depends on lpfd_pkg.
`default_nettype none

module lpfd_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire lpfd_pkg::lpfd_result_t din,
  output logic                   room,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lpfd_pkg::lpfd_result_t dout
);
  import lpfd_pkg::*;

  lpfd_result_t mem_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  logic         pop;

  assign pop       = out_valid && out_ready;
  assign out_valid = count_r != 2'd0;
  assign room      = count_r != 2'd2;
  assign dout      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r != 2'd2)
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("buffer count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> wr_ptr_r != rd_ptr_r)
    else $error("buffer pointers disagree with count");
`endif

endmodule

`default_nettype wire

>>> hdl/length_prefixed_frame_deframer.sv
// Top level of the length-prefixed frame deframer.
// Uses lpfd_pkg, lpfd_if, lpfd_cfg_regs, lpfd_parse and lpfd_out_buf.
//
//   channel   dir   transaction
//   in_ch     in    kind (0 byte, 1 release) + rx_byte
//   out_ch    out   payload byte, packet complete or packet dropped
//   cfg_*     in    register write, index + data, no read-back
//
// One input transaction per cycle while in_ch.ready is high; its result is registered
// and shows on out_ch the next cycle at the earliest. in_ch.ready drops only when the two-entry
// result buffer is full, so one result can wait on a stalled out_ch without stopping the input.
// Synchronous active-low reset; control and config registers take their default values, result storage is not reset.
`default_nettype none

module length_prefixed_frame_deframer (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  lpfd_in_if.sink                             in_ch,
  lpfd_out_if.source                          out_ch,
  input  wire logic                           cfg_we,
  input  wire logic [lpfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpfd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lpfd_pkg::*;

  lpfd_cfg_t    cfg;
  lpfd_result_t res;
  lpfd_result_t dout;
  logic         res_valid;
  logic         room;
  logic         acc;

  assign in_ch.ready = room;
  assign acc         = in_ch.valid && room;

  lpfd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpfd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .kind      (in_ch.kind),
    .rx_byte   (in_ch.rx_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  lpfd_out_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .din       (res),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .dout      (dout)
  );

  assign out_ch.result_kind    = dout.result_kind;
  assign out_ch.payload_byte   = dout.payload_byte;
  assign out_ch.payload_index  = dout.payload_index;
  assign out_ch.is_reply       = dout.is_reply;
  assign out_ch.machine_kind   = dout.machine_kind;
  assign out_ch.machine_number = dout.machine_number;
  assign out_ch.command_code   = dout.command_code;
  assign out_ch.payload_length = dout.payload_length;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// Self-checking testbench for length_prefixed_frame_deframer.
// Drives framed byte streams with faults and register changes, predicts every result.
// Depends on lpfd_pkg, lpfd_if and the deframer RTL.
`timescale 1ns / 1ps

module testbench;
  import lpfd_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES = 4;

  typedef enum int unsigned {
    PK_GOOD,
    PK_CUT,
    PK_BAD_TYPE,
    PK_BAD_VERSION,
    PK_BAD_KEYVER,
    PK_LONG,
    PK_BAD_SUM,
    PK_BAD_END
  } pkt_fault_t;

  class deframe_tracker;
    lpfd_cfg_t    regs;
    lpfd_step_t   step;
    logic [7:0]   xor_acc;
    logic [15:0]  count;
    logic [15:0]  flen;
    bit           held;
    bit           reply;
    logic [7:0]   mkind;
    logic [31:0]  mnum;
    logic [7:0]   cmd;
    lpfd_result_t pending_results[$];
    int unsigned  failures;

    function new();
      regs.header_value      = RST_HEADER;
      regs.ask_type_value    = RST_ASK_TYPE;
      regs.reply_type_value  = RST_REPLY_TYPE;
      regs.version_value     = RST_VERSION;
      regs.key_version_value = RST_KEY_VERSION;
      regs.end_value         = RST_END;
      regs.length_limit      = RST_LEN_LIMIT;
      regs.check_enable      = RST_CHECK_EN;
      step = ST_HUNT;
      xor_acc = '0;
      count = '0;
      flen = '0;
      held = 1'b0;
      reply = 1'b0;
      mkind = '0;
      mnum = '0;
      cmd = '0;
      failures = 0;
    endfunction

    function void write_reg(lpfd_reg_t idx, logic [15:0] v);
      case (idx)
        REG_HEADER:      regs.header_value = v[7:0];
        REG_ASK_TYPE:    regs.ask_type_value = v[7:0];
        REG_REPLY_TYPE:  regs.reply_type_value = v[7:0];
        REG_VERSION:     regs.version_value = v[7:0];
        REG_KEY_VERSION: regs.key_version_value = v[7:0];
        REG_END:         regs.end_value = v[7:0];
        REG_LEN_LIMIT:   regs.length_limit = v;
        REG_CHECK_EN:    regs.check_enable = v[0];
        default: ;
      endcase
    endfunction

    function void push_result(lpfd_rkind_t rk, logic [7:0] pb, logic [15:0] pi);
      lpfd_result_t r;
      r.result_kind    = rk;
      r.payload_byte   = pb;
      r.payload_index  = pi;
      r.is_reply       = reply;
      r.machine_kind   = mkind;
      r.machine_number = mnum;
      r.command_code   = cmd;
      r.payload_length = flen;
      pending_results.push_back(r);
    endfunction

    function void drop_packet();
      step = ST_HUNT;
      push_result(RK_DROP, 8'h00, 16'h0000);
    endfunction

    function void note_input(bit kind, logic [7:0] b);
      logic [15:0] idx;
      if (kind) begin
        held = 1'b0;
        return;
      end
      case (step)
        ST_HUNT: begin
          if (b == regs.header_value && !held) begin
            xor_acc = '0;
            count = '0;
            flen = '0;
            reply = 1'b0;
            mkind = '0;
            mnum = '0;
            cmd = '0;
            step = ST_TYPE;
          end
        end
        ST_TYPE: begin
          if (b == regs.ask_type_value) begin
            reply = 1'b0;
            step = ST_VERSION;
          end else if (b == regs.reply_type_value) begin
            reply = 1'b1;
            step = ST_VERSION;
          end else begin
            drop_packet();
          end
        end
        ST_VERSION: begin
          if (b != regs.version_value) begin
            drop_packet();
          end else begin
            xor_acc = b;
            step = ST_MKIND;
          end
        end
        ST_MKIND: begin
          mkind = b;
          xor_acc ^= b;
          step = ST_MNUM0;
        end
        ST_MNUM0: begin
          mnum = {24'h0, b};
          xor_acc ^= b;
          step = ST_MNUM1;
        end
        ST_MNUM1: begin
          mnum[15:8] = b;
          xor_acc ^= b;
          step = ST_MNUM2;
        end
        ST_MNUM2: begin
          mnum[23:16] = b;
          xor_acc ^= b;
          step = ST_MNUM3;
        end
        ST_MNUM3: begin
          mnum[31:24] = b;
          xor_acc ^= b;
          step = ST_KEYVER;
        end
        ST_KEYVER: begin
          if (b != regs.key_version_value) begin
            drop_packet();
          end else begin
            xor_acc ^= b;
            step = ST_CMD;
          end
        end
        ST_CMD: begin
          cmd = b;
          xor_acc ^= b;
          step = ST_LEN_LO;
        end
        ST_LEN_LO: begin
          flen = {8'h00, b};
          xor_acc ^= b;
          step = ST_LEN_HI;
        end
        ST_LEN_HI: begin
          flen[15:8] = b;
          xor_acc ^= b;
          if (flen == 16'h0000) step = ST_CHECK;
          else if (flen >= regs.length_limit) drop_packet();
          else step = ST_PAYLOAD;
        end
        ST_PAYLOAD: begin
          idx = count;
          count = count + 16'd1;
          xor_acc ^= b;
          if (count >= flen) step = ST_CHECK;
          push_result(RK_PAYLOAD, b, idx);
        end
        ST_CHECK: begin
          if (regs.check_enable && xor_acc != b) drop_packet();
          else step = ST_END;
        end
        ST_END: begin
          if (b != regs.end_value) begin
            drop_packet();
          end else begin
            held = 1'b1;
            step = ST_HUNT;
            push_result(RK_DONE, 8'h00, 16'h0000);
          end
        end
        default: begin
          step = ST_HUNT;
          xor_acc = '0;
          count = '0;
        end
      endcase
    endfunction

    function void note_error(string msg);
      failures++;
      if (failures <= 10) $display("MISMATCH at %0t: %s", $time, msg);
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) note_error($sformatf("%s expected 0x%0h got 0x%0h", field, want, got));
    endfunction

    function void check_result(lpfd_result_t got);
      lpfd_result_t want;
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result, kind 0x%0h", got.result_kind));
        return;
      end
      want = pending_results.pop_front();
      compare_field("result_kind", want.result_kind, got.result_kind);
      compare_field("payload_byte", want.payload_byte, got.payload_byte);
      compare_field("payload_index", want.payload_index, got.payload_index);
      compare_field("is_reply", want.is_reply, got.is_reply);
      compare_field("machine_kind", want.machine_kind, got.machine_kind);
      compare_field("machine_number", want.machine_number, got.machine_number);
      compare_field("command_code", want.command_code, got.command_code);
      compare_field("payload_length", want.payload_length, got.payload_length);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lpfd_in_if  in_ch();
  lpfd_out_if out_ch();

  deframe_tracker tracker = new();
  lpfd_result_t seen_result;
  int unsigned idle_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  bit quiet = 1'b0;

  length_prefixed_frame_deframer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int unsigned gap_cycles();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [15:0] pick_length(int unsigned lim);
    int unsigned r;
    int unsigned top;
    if (lim <= 1) return 16'h0000;
    top = (lim - 1 < 48) ? lim - 1 : 48;
    r = $urandom_range(0, 99);
    if (r < 20) return 16'h0000;
    if (r < 30) return 16'(top);
    if (r < 85) return 16'($urandom_range(1, (top < 6) ? top : 6));
    return 16'($urandom_range(1, top));
  endfunction

  function automatic logic [7:0] other_than(logic [7:0] v);
    return v ^ 8'($urandom_range(1, 255));
  endfunction

  // sample at the rising edge: results first, then the input transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen_result.result_kind    = lpfd_rkind_t'(out_ch.result_kind);
        seen_result.payload_byte   = out_ch.payload_byte;
        seen_result.payload_index  = out_ch.payload_index;
        seen_result.is_reply       = out_ch.is_reply;
        seen_result.machine_kind   = out_ch.machine_kind;
        seen_result.machine_number = out_ch.machine_number;
        seen_result.command_code   = out_ch.command_code;
        seen_result.payload_length = out_ch.payload_length;
        tracker.check_result(seen_result);
      end
      if (in_ch.valid && in_ch.ready) tracker.note_input(in_ch.kind, in_ch.rx_byte);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 99) < 25) begin
      out_ch.ready = 1'b0;
      stall_left = gap_cycles() - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  task automatic send_item(bit kind, logic [7:0] b);
    int unsigned gap;
    gap = (!quiet && $urandom_range(0, 99) < 30) ? gap_cycles() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.kind = kind;
    in_ch.rx_byte = b;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // hold the input idle until every expected result is out
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lpfd_reg_t idx, logic [15:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    tracker.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic configure(lpfd_cfg_t c);
    drain();
    write_reg(REG_HEADER, {8'($urandom), c.header_value});
    write_reg(REG_ASK_TYPE, {8'($urandom), c.ask_type_value});
    write_reg(REG_REPLY_TYPE, {8'($urandom), c.reply_type_value});
    write_reg(REG_VERSION, {8'($urandom), c.version_value});
    write_reg(REG_KEY_VERSION, {8'($urandom), c.key_version_value});
    write_reg(REG_END, {8'($urandom), c.end_value});
    write_reg(REG_LEN_LIMIT, c.length_limit);
    write_reg(REG_CHECK_EN, {15'($urandom), c.check_enable});
  endtask

  task automatic send_packet(pkt_fault_t fault, bit reply, logic [7:0] mkind,
                             logic [31:0] mnum, logic [7:0] cmd, logic [15:0] len);
    logic [7:0] frame[$];
    logic [7:0] sum;
    logic [7:0] b;
    int unsigned stop_at;
    int unsigned i;
    stop_at = 0;
    if (fault == PK_LONG) len = 16'($urandom_range(tracker.regs.length_limit, 65535));
    frame.push_back(tracker.regs.header_value);
    if (fault == PK_BAD_TYPE) begin
      do b = 8'($urandom); while (b == tracker.regs.ask_type_value ||
                                   b == tracker.regs.reply_type_value);
      frame.push_back(b);
      stop_at = frame.size();
    end else begin
      frame.push_back(reply ? tracker.regs.reply_type_value : tracker.regs.ask_type_value);
    end
    if (fault == PK_BAD_VERSION) begin
      frame.push_back(other_than(tracker.regs.version_value));
      if (stop_at == 0) stop_at = frame.size();
    end else begin
      frame.push_back(tracker.regs.version_value);
    end
    frame.push_back(mkind);
    for (i = 0; i < 4; i++) frame.push_back(mnum[8*i +: 8]);
    if (fault == PK_BAD_KEYVER) begin
      frame.push_back(other_than(tracker.regs.key_version_value));
      if (stop_at == 0) stop_at = frame.size();
    end else begin
      frame.push_back(tracker.regs.key_version_value);
    end
    frame.push_back(cmd);
    frame.push_back(len[7:0]);
    frame.push_back(len[15:8]);
    if (fault == PK_LONG && stop_at == 0) stop_at = frame.size();
    if (stop_at == 0) begin
      for (i = 0; i < len; i++) frame.push_back(8'($urandom));
      sum = '0;
      for (i = 2; i < frame.size(); i++) sum ^= frame[i];
      frame.push_back((fault == PK_BAD_SUM) ? sum ^ (8'h01 << $urandom_range(0, 7)) : sum);
      frame.push_back((fault == PK_BAD_END) ? other_than(tracker.regs.end_value)
                                            : tracker.regs.end_value);
      if (fault == PK_CUT) stop_at = $urandom_range(1, frame.size() - 1);
    end
    if (stop_at == 0) stop_at = frame.size();
    for (i = 0; i < stop_at; i++) send_item(1'b0, frame[i]);
  endtask

  task automatic random_traffic(int unsigned n);
    int unsigned stop_count;
    int unsigned r;
    bit unbounded;
    pkt_fault_t fault;
    stop_count = items_sent + n;
    // a stray header could open a huge payload when the limit is high
    unbounded = tracker.regs.length_limit > 600;
    while (items_sent < stop_count) begin
      r = $urandom_range(0, 99);
      if (r < 8 && !unbounded) begin
        repeat ($urandom_range(1, 3)) send_item(1'b0, 8'($urandom));
      end else if (r < 13) begin
        send_item(1'b1, 8'($urandom));
      end else begin
        if (r < 20) fault = unbounded ? PK_GOOD : PK_CUT;
        else if (r < 25) fault = PK_BAD_TYPE;
        else if (r < 30) fault = PK_BAD_VERSION;
        else if (r < 35) fault = PK_BAD_KEYVER;
        else if (r < 42) fault = PK_LONG;
        else if (r < 49) fault = PK_BAD_SUM;
        else if (r < 56) fault = PK_BAD_END;
        else fault = PK_GOOD;
        send_packet(fault, 1'($urandom), 8'($urandom), $urandom, 8'($urandom),
                    pick_length(tracker.regs.length_limit));
        if ($urandom_range(0, 99) < 70) send_item(1'b1, 8'($urandom));
      end
    end
  endtask

  initial begin
    lpfd_cfg_t c;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_HEADER;
    cfg_data = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // noise while hunting, full-scale zero-length request, header while held,
    // release, a reply with a bad version, then a one-byte reply and a release
    send_item(1'b0, 8'h00);
    send_packet(PK_GOOD, 1'b0, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 16'h0000);
    send_item(1'b0, tracker.regs.header_value);
    send_item(1'b1, 8'hFF);
    send_packet(PK_BAD_VERSION, 1'b1, 8'h00, 32'h0, 8'h00, 16'h0001);
    send_packet(PK_GOOD, 1'b1, 8'h00, 32'h0, 8'h00, 16'h0001);
    send_item(1'b1, 8'h00);

    random_traffic(180);

    c = '{header_value: 8'h00, ask_type_value: 8'hFF, reply_type_value: 8'h00,
          version_value: 8'hFF, key_version_value: 8'h00, end_value: 8'hFF,
          length_limit: 16'd1, check_enable: 1'b0};
    configure(c);
    random_traffic(80);

    // ask and reply share one code; no idling on either side
    quiet = 1'b1;
    c = '{header_value: 8'hFF, ask_type_value: 8'h5A, reply_type_value: 8'h5A,
          version_value: 8'h00, key_version_value: 8'hFF, end_value: 8'h00,
          length_limit: 16'hFFFF, check_enable: 1'b1};
    configure(c);
    random_traffic(80);
    quiet = 1'b0;

    repeat (5) begin
      c.header_value      = 8'($urandom);
      c.ask_type_value    = 8'($urandom);
      c.reply_type_value  = 8'($urandom);
      c.version_value     = 8'($urandom);
      c.key_version_value = 8'($urandom);
      c.end_value         = 8'($urandom);
      c.length_limit      = 16'($urandom_range(2, 40));
      c.check_enable      = 1'($urandom);
      configure(c);
      random_traffic(60);
    end

    drain();
    if (tracker.failures == 0 && tracker.pending_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/lpfd_pkg.sv
hdl/lpfd_if.sv
hdl/lpfd_cfg_regs.sv
hdl/lpfd_parse.sv
hdl/lpfd_out_buf.sv
hdl/length_prefixed_frame_deframer.sv
verif/testbench.sv
